[rtl/swpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sine wave point displacement: shared package
// Item types, register indexes, lane and control structs, and helpers used
// by the datapath and the table generator.
// ============================================================================
package swpd_pkg;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LANE_W     = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_AMPLITUDES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_FREQUENCIES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_DIRS_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_DIRS_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SPEEDS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_OFFSETS     = 3'd5;

    // Table entries are signed Q0.16 and can reach plus or minus one half.
    localparam int ROM_W = 17;

    // Fixed-point constants of the cosine generator.
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [37:0] Q30_ONE     = 38'sd1073741824;
    localparam int GEN_DIV_W = 32;

    typedef struct packed {
        logic signed [31:0] m_scale_x;
        logic signed [31:0] m_skew_y;
        logic signed [31:0] m_skew_x;
        logic signed [31:0] m_scale_y;
        logic signed [31:0] m_trans_x;
        logic signed [31:0] m_trans_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic        [31:0] time_sec;
    } swpd_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
    } swpd_out_t;

    // Per-wave coefficients taken from the configuration registers.
    typedef struct packed {
        logic signed [LANE_W-1:0] amp;
        logic signed [LANE_W-1:0] freq;
        logic signed [LANE_W-1:0] dirx;
        logic signed [LANE_W-1:0] diry;
        logic signed [LANE_W-1:0] spd;
        logic        [LANE_W-1:0] off;
    } swpd_lane_t;

    // Load enables of the wave stages.
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
        logic s8;
        logic s9;
        logic s10;
        logic s11;
    } swpd_wave_en_t;

    // Table generator sequencer states.
    typedef enum logic [2:0] {
        GEN_ANGLE,
        GEN_MUL_X,
        GEN_MUL_X2,
        GEN_MUL_ACC,
        GEN_DIV,
        GEN_NEXT,
        GEN_WRITE,
        GEN_DONE
    } swpd_gen_state_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Reciprocal of the divisor (2k-1)(2k) of Horner step k, rounded up.
    // Exact for any dividend below 2^32 together with the matching shift.
    function automatic logic signed [33:0] horner_recip(input logic [2:0] k);
        logic signed [33:0] m;
        unique case (k)
            3'd6:    m = 34'sd8329633544;
            3'd5:    m = 34'sd6108397933;
            3'd4:    m = 34'sd4908534053;
            3'd3:    m = 34'sd4581298450;
            3'd2:    m = 34'sd5726623062;
            default: m = 34'sd2147483648;
        endcase
        return m;
    endfunction

    // Right shift that goes with the reciprocal of Horner step k.
    function automatic logic [5:0] horner_shift(input logic [2:0] k);
        logic [5:0] s;
        unique case (k)
            3'd6:    s = 6'd40;
            3'd5:    s = 6'd39;
            3'd4:    s = 6'd38;
            3'd3:    s = 6'd37;
            3'd2:    s = 6'd36;
            default: s = 6'd32;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/swpd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generic RAM
// One write port and two read ports with registered, enabled read data.
// ============================================================================
module swpd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4097
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; data holds while the read enable is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

[rtl/swpd_rom_gen.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sine table generator
// After reset, computes each entry -cos(2*pi*i/2^TABLE_BITS)/2 with a Q30
// Horner cosine over a quarter turn and writes it to the wave tables.
// ============================================================================
module swpd_rom_gen
    import swpd_pkg::*;
#(
    parameter int TABLE_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    output logic                       rom_we,
    output logic [TABLE_BITS:0]        rom_addr,
    output logic [ROM_W-1:0]           rom_data,
    output logic                       done
);

    localparam int AW = TABLE_BITS + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(1) << TABLE_BITS;

    swpd_gen_state_t state_reg, state_next;

    logic [AW-1:0]           idx_reg, idx_next;
    logic [2:0]              k_reg, k_next;
    logic [30:0]             rp_reg, rp_next;
    logic                    flip_reg, flip_next;
    logic [30:0]             x_reg, x_next;
    logic [32:0]             x2_reg, x2_next;
    logic signed [31:0]      acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [GEN_DIV_W-1:0]    mag_reg, mag_next;
    logic [GEN_DIV_W-1:0]    quo_reg, quo_next;

    logic signed [33:0]      mul_a, mul_b;
    logic signed [67:0]      mul_p;

    // Shared multiplier; its product is registered in every state that uses it.
    assign mul_p = mul_a * mul_b;

    // State register and sequencing counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GEN_ANGLE;
            idx_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        rp_reg   <= rp_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        quo_reg  <= quo_next;
    end

    // Next state, datapath and table write.
    always_comb
    begin
        logic [31:0]        angle;
        logic signed [35:0] dvd;
        logic signed [37:0] q_s;
        logic signed [32:0] c_val;
        logic signed [32:0] c_rnd;
        logic signed [18:0] ent;

        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        rp_next    = rp_reg;
        flip_next  = flip_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        quo_next   = quo_reg;
        mul_a      = '0;
        mul_b      = '0;
        rom_we     = 1'b0;
        rom_addr   = idx_reg;
        rom_data   = '0;

        angle  = {idx_reg[TABLE_BITS-1:0], {(32 - TABLE_BITS){1'b0}}};
        dvd    = 36'(mul_p >>> 30);
        q_s    = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        c_val  = flip_reg ? -33'(acc_reg) : 33'(acc_reg);
        c_rnd  = c_val + 33'sd16384;
        ent    = -19'(c_rnd >>> 15);

        unique case (state_reg)
            // Fold the angle into a quarter turn and note the sign of the result.
            GEN_ANGLE:
            begin
                if (angle[31:30] == 2'd0 || angle[31:30] == 2'd2)
                begin
                    rp_next = {1'b0, angle[29:0]};
                end
                else
                begin
                    rp_next = 31'(31'h40000000 - {1'b0, angle[29:0]});
                end
                flip_next  = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
                acc_next   = 32'(Q30_ONE);
                k_next     = 3'd6;
                state_next = GEN_MUL_X;
            end
            // Angle in radians, Q30.
            GEN_MUL_X:
            begin
                mul_a      = $signed({3'b000, rp_reg});
                mul_b      = HALF_PI_Q30;
                x_next     = 31'(mul_p >>> 30);
                state_next = GEN_MUL_X2;
            end
            // Square of the angle, Q30.
            GEN_MUL_X2:
            begin
                mul_a      = $signed({3'b000, x_reg});
                mul_b      = $signed({3'b000, x_reg});
                x2_next    = 33'(mul_p >>> 30);
                state_next = GEN_MUL_ACC;
            end
            // One Horner product, then split it into sign and magnitude.
            GEN_MUL_ACC:
            begin
                mul_a      = $signed({1'b0, x2_reg});
                mul_b      = 34'(acc_reg);
                neg_next   = dvd[35];
                mag_next   = dvd[35] ? GEN_DIV_W'(-dvd) : GEN_DIV_W'(dvd);
                state_next = GEN_DIV;
            end
            // Divide the magnitude by the step's divisor with its reciprocal.
            GEN_DIV:
            begin
                mul_a      = $signed({2'b00, mag_reg});
                mul_b      = horner_recip(k_reg);
                quo_next   = GEN_DIV_W'(mul_p >> horner_shift(k_reg));
                state_next = GEN_NEXT;
            end
            // Quotient truncated toward zero closes the Horner step.
            GEN_NEXT:
            begin
                acc_next = 32'(Q30_ONE - q_s);
                if (k_reg == 3'd1)
                begin
                    state_next = GEN_WRITE;
                end
                else
                begin
                    k_next     = k_reg - 3'd1;
                    state_next = GEN_MUL_ACC;
                end
            end
            // Round to Q0.16, negate and store the entry.
            GEN_WRITE:
            begin
                rom_we   = 1'b1;
                rom_data = ROM_W'(ent);
                if (idx_reg == LAST_IDX)
                begin
                    state_next = GEN_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = GEN_ANGLE;
                end
            end
            GEN_DONE:
            begin
                state_next = GEN_DONE;
            end
            default:
            begin
                state_next = GEN_ANGLE;
            end
        endcase
    end

    assign done = (state_reg == GEN_DONE);

endmodule
`default_nettype wire

[rtl/swpd_wave.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sine wave point displacement: one wave lane
// Stages 3 to 11: projection, phase, table lookup with linear interpolation,
// amplitude scaling and the two displacement products of one wave.
// ============================================================================
module swpd_wave
    import swpd_pkg::*;
#(
    parameter int TABLE_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire swpd_wave_en_t                 en,
    input  wire swpd_lane_t                    lane,
    input  wire logic signed [31:0]            dev_x,
    input  wire logic signed [31:0]            dev_y,
    input  wire logic        [31:0]            t_sec,
    input  wire logic                          rom_we,
    input  wire logic        [TABLE_BITS:0]    rom_addr,
    input  wire logic        [ROM_W-1:0]       rom_data,
    output logic signed      [FRAC_BITS+27:0]  hx,
    output logic signed      [FRAC_BITS+27:0]  hy
);

    localparam int AW   = TABLE_BITS + 1;
    localparam int DEPTH = (1 << TABLE_BITS) + 1;
    localparam int PW   = 48;
    localparam int PLW  = FRAC_BITS + 19;
    localparam int VW   = FRAC_BITS + 20;
    localparam int AHW  = FRAC_BITS + 36;
    localparam int HW   = FRAC_BITS + 12;
    localparam int HTW  = FRAC_BITS + 28;

    logic signed [47:0]            pdx_reg, pdy_reg;
    logic signed [48:0]            st3_reg, st4_reg, st5_reg;
    logic signed [33:0]            proj_reg;
    logic signed [49:0]            fp_reg;
    logic        [TABLE_BITS-1:0]  idx_reg;
    logic        [FRAC_BITS-1:0]   frac6_reg, frac7_reg;
    logic        [ROM_W-1:0]       left_q, right_q;
    logic signed [PLW-1:0]         pl_reg, pr_reg;
    logic signed [VW-1:0]          val_reg;
    logic signed [AHW-1:0]         ah_reg;
    logic signed [HTW-1:0]         hx_reg, hy_reg;

    logic signed [47:0]            pdx_next, pdy_next;
    logic signed [48:0]            st_next;
    logic signed [48:0]            psum;
    logic signed [49:0]            fp_next;
    logic signed [PW-1:0]          phase;
    logic        [PW-1:0]          phase_mag;
    logic        [FRAC_BITS:0]     wl_u;
    logic signed [PLW-1:0]         pl_next, pr_next;
    logic signed [HW-1:0]          h;
    logic signed [HTW-1:0]         hx_next, hy_next;
    logic        [AW-1:0]          raddr_a, raddr_b;

    // Stage 3: projection products and the time term.
    assign pdx_next = dev_x * lane.dirx;
    assign pdy_next = dev_y * lane.diry;
    assign st_next  = lane.spd * $signed({1'b0, t_sec});

    // Stages 4 and 5: projection sum, then spatial frequency times the projection.
    assign psum    = 49'(pdx_reg) + 49'(pdy_reg);
    assign fp_next = lane.freq * proj_reg;

    // Stage 6: phase magnitude split into table index and fraction.
    assign phase = PW'(fp_reg >>> 12) + PW'(st5_reg >>> 4)
                 + $signed(PW'(lane.off) << FRAC_BITS);
    assign phase_mag = phase[PW-1] ? PW'(-phase) : phase;

    // Table addresses of the two neighbors.
    assign raddr_a = {1'b0, idx_reg};
    assign raddr_b = {1'b0, idx_reg} + AW'(1);

    // Stage 8: interpolation weights.
    assign wl_u    = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac7_reg};
    assign pl_next = $signed(left_q) * $signed({1'b0, wl_u});
    assign pr_next = $signed(right_q) * $signed({1'b0, frac7_reg});

    // Stage 11: height and its two displacement products.
    assign h       = HW'(ah_reg >>> 24);
    assign hx_next = h * lane.dirx;
    assign hy_next = h * lane.diry;

    swpd_ram #(
        .WIDTH (ROM_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (rom_we),
        .waddr   (rom_addr),
        .wdata   (rom_data),
        .re      (en.s7),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (left_q),
        .rdata_b (right_q)
    );

    // Pipeline registers, each loaded when its stage advances.
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            pdx_reg <= pdx_next;
            pdy_reg <= pdy_next;
            st3_reg <= st_next;
        end
        if (en.s4)
        begin
            proj_reg <= 34'(psum >>> 15);
            st4_reg  <= st3_reg;
        end
        if (en.s5)
        begin
            fp_reg  <= fp_next;
            st5_reg <= st4_reg;
        end
        if (en.s6)
        begin
            idx_reg   <= phase_mag[FRAC_BITS +: TABLE_BITS];
            frac6_reg <= phase_mag[FRAC_BITS-1:0];
        end
        if (en.s7)
        begin
            frac7_reg <= frac6_reg;
        end
        if (en.s8)
        begin
            pl_reg <= pl_next;
            pr_reg <= pr_next;
        end
        if (en.s9)
        begin
            val_reg <= VW'(pl_reg) + VW'(pr_reg);
        end
        if (en.s10)
        begin
            ah_reg <= val_reg * lane.amp;
        end
        if (en.s11)
        begin
            hx_reg <= hx_next;
            hy_reg <= hy_next;
        end
    end

    assign hx = hx_reg;
    assign hy = hy_reg;

endmodule
`default_nettype wire

[rtl/sine_wave_point_displacement_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sine wave point displacement unit
// Maps a point through a 2x3 affine matrix and displaces it by the sum of up
// to four traveling sine waves.
// ============================================================================
// The unit is a 12-stage pipeline that takes one item per clock while in_ready
// is high. An output stall holds only the stages that are full, so bubbles
// close up and in_ready stays high while any stage is free. Each wave has its
// own dual-read sine table memory. After reset the tables are filled by a
// single cosine sequencer, 2^TABLE_BITS + 1 entries (4097 at the default);
// in_ready stays low until the fill is done. Configuration writes are taken
// at any time and should be made only while no item is in flight.
// ============================================================================
module sine_wave_point_displacement_unit
    import swpd_pkg::*;
#(
    parameter int TABLE_BITS = 12,
    parameter int NUM_WAVES  = 4,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire swpd_in_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output swpd_out_t                   out_data
);

    localparam int NST = 12;
    localparam int HTW = FRAC_BITS + 28;
    localparam int TW  = FRAC_BITS + 13;
    localparam int SW  = ((TW > 32) ? TW : 32) + 3;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] wave_amplitudes_reg;
    logic [CFG_DATA_W-1:0] wave_frequencies_reg;
    logic [CFG_DATA_W-1:0] wave_dirs_x_reg;
    logic [CFG_DATA_W-1:0] wave_dirs_y_reg;
    logic [CFG_DATA_W-1:0] wave_speeds_reg;
    logic [CFG_DATA_W-1:0] wave_offsets_reg;

    // Pipeline control.
    logic [NST:1] v_reg;
    logic [NST:1] v_src;
    logic [NST:1] rdy;
    logic         v_in;
    logic         gen_done;
    swpd_wave_en_t wave_en;

    // Table fill.
    logic                   rom_we;
    logic [TABLE_BITS:0]    rom_addr;
    logic [ROM_W-1:0]       rom_data;

    // Stage 1 and 2 data.
    logic signed [63:0] p_sx_reg, p_kx_reg, p_ky_reg, p_sy_reg;
    logic signed [63:0] p_sx_next, p_kx_next, p_ky_next, p_sy_next;
    logic signed [31:0] tx1_reg, ty1_reg;
    logic        [31:0] t1_reg, t2_reg;
    logic signed [65:0] devx_sum, devy_sum;
    logic signed [31:0] devx2_reg, devy2_reg;
    logic signed [31:0] devx_d [3:11];
    logic signed [31:0] devy_d [3:11];

    // Wave results and the output stage.
    logic signed [HTW-1:0] hx_term [NUM_WAVES];
    logic signed [HTW-1:0] hy_term [NUM_WAVES];
    logic signed [SW-1:0]  sum_x, sum_y;
    logic signed [31:0]    out_x_reg, out_y_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_amplitudes_reg  <= '0;
            wave_frequencies_reg <= '0;
            wave_dirs_x_reg      <= '0;
            wave_dirs_y_reg      <= '0;
            wave_speeds_reg      <= '0;
            wave_offsets_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WAVE_AMPLITUDES:  wave_amplitudes_reg  <= cfg_data;
                REG_WAVE_FREQUENCIES: wave_frequencies_reg <= cfg_data;
                REG_WAVE_DIRS_X:      wave_dirs_x_reg      <= cfg_data;
                REG_WAVE_DIRS_Y:      wave_dirs_y_reg      <= cfg_data;
                REG_WAVE_SPEEDS:      wave_speeds_reg      <= cfg_data;
                REG_WAVE_OFFSETS:     wave_offsets_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or the stage after it is moving.
    always_comb
    begin
        rdy[NST] = ~v_reg[NST] | out_ready;
        for (int i = NST - 1; i >= 1; i--)
        begin
            rdy[i] = ~v_reg[i] | rdy[i + 1];
        end
    end

    assign v_in     = in_valid & gen_done;
    assign in_ready = rdy[1] & gen_done;
    assign v_src    = {v_reg[NST-1:1], v_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (rdy & v_src) | (~rdy & v_reg);
        end
    end

    assign wave_en.s3  = rdy[3];
    assign wave_en.s4  = rdy[4];
    assign wave_en.s5  = rdy[5];
    assign wave_en.s6  = rdy[6];
    assign wave_en.s7  = rdy[7];
    assign wave_en.s8  = rdy[8];
    assign wave_en.s9  = rdy[9];
    assign wave_en.s10 = rdy[10];
    assign wave_en.s11 = rdy[11];

    swpd_rom_gen #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .rom_we   (rom_we),
        .rom_addr (rom_addr),
        .rom_data (rom_data),
        .done     (gen_done)
    );

    // Stage 1: matrix products.
    assign p_sx_next = in_data.m_scale_x * in_data.point_x;
    assign p_kx_next = in_data.m_skew_x  * in_data.point_y;
    assign p_ky_next = in_data.m_skew_y  * in_data.point_x;
    assign p_sy_next = in_data.m_scale_y * in_data.point_y;

    // Stage 2: device point, saturated.
    assign devx_sum = 66'(p_sx_reg >>> FRAC_BITS) + 66'(p_kx_reg >>> FRAC_BITS)
                    + 66'(tx1_reg);
    assign devy_sum = 66'(p_ky_reg >>> FRAC_BITS) + 66'(p_sy_reg >>> FRAC_BITS)
                    + 66'(ty1_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            p_sx_reg <= p_sx_next;
            p_kx_reg <= p_kx_next;
            p_ky_reg <= p_ky_next;
            p_sy_reg <= p_sy_next;
            tx1_reg  <= in_data.m_trans_x;
            ty1_reg  <= in_data.m_trans_y;
            t1_reg   <= in_data.time_sec;
        end
        if (rdy[2])
        begin
            devx2_reg <= sat32(devx_sum);
            devy2_reg <= sat32(devy_sum);
            t2_reg    <= t1_reg;
        end
        if (rdy[3])
        begin
            devx_d[3] <= devx2_reg;
            devy_d[3] <= devy2_reg;
        end
    end

    // Device point travels alongside the wave stages.
    for (genvar s = 4; s <= 11; s++)
    begin : g_dev_delay
        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                devx_d[s] <= devx_d[s - 1];
                devy_d[s] <= devy_d[s - 1];
            end
        end
    end

    // Wave lanes.
    for (genvar k = 0; k < NUM_WAVES; k++)
    begin : g_wave
        swpd_lane_t lane;

        assign lane.amp  = wave_amplitudes_reg[LANE_W*k +: LANE_W];
        assign lane.freq = wave_frequencies_reg[LANE_W*k +: LANE_W];
        assign lane.dirx = wave_dirs_x_reg[LANE_W*k +: LANE_W];
        assign lane.diry = wave_dirs_y_reg[LANE_W*k +: LANE_W];
        assign lane.spd  = wave_speeds_reg[LANE_W*k +: LANE_W];
        assign lane.off  = wave_offsets_reg[LANE_W*k +: LANE_W];

        swpd_wave #(
            .TABLE_BITS (TABLE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_wave (
            .clk      (clk),
            .en       (wave_en),
            .lane     (lane),
            .dev_x    (devx2_reg),
            .dev_y    (devy2_reg),
            .t_sec    (t2_reg),
            .rom_we   (rom_we),
            .rom_addr (rom_addr),
            .rom_data (rom_data),
            .hx       (hx_term[k]),
            .hy       (hy_term[k])
        );
    end

    // Stage 12: sum the wave displacements and saturate.
    always_comb
    begin
        sum_x = SW'(devx_d[11]);
        sum_y = SW'(devy_d[11]);
        for (int k = 0; k < NUM_WAVES; k++)
        begin
            sum_x = sum_x + SW'(hy_term[k] >>> 15);
            sum_y = sum_y - SW'(hx_term[k] >>> 15);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST])
        begin
            out_x_reg <= sat32(66'(sum_x));
            out_y_reg <= sat32(66'(sum_y));
        end
    end

    assign out_valid      = v_reg[NST];
    assign out_data.out_x = out_x_reg;
    assign out_data.out_y = out_y_reg;

endmodule
`default_nettype wire

[rtl/swpd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sine wave point displacement: port checker
// Watches the top-level ports for output hold and start-up behavior.
// ============================================================================
module swpd_checker
    import swpd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire swpd_out_t out_data
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result item changed while stalled");

    // The table fill keeps the input closed right after reset.
    a_fill_blocks: assert property (@(posedge clk)
        !$past(rst_n) |-> !in_ready)
        else $error("item accepted before the tables were filled");

    // No result can appear sooner than the pipeline depth after reset.
    a_no_early_out: assert property (@(posedge clk)
        out_valid |-> $past(rst_n, 12))
        else $error("result item without a pipeline pass");

endmodule

bind sine_wave_point_displacement_unit swpd_checker u_swpd_checker (.*);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the sine wave point displacement unit
// Sends affine matrices, points and times under several wave settings. Each
// result is checked against a local fixed-point model of the mapping, the
// table lookup and the wave sums, with random idling on both channels.
// ============================================================================
module testbench;
    import swpd_pkg::*;

    localparam int      TBL_BITS       = 12;
    localparam int      TBL_SIZE       = 1 << TBL_BITS;
    localparam int      FRAC           = 16;
    localparam int      IDLE_LIMIT     = 2000000;
    localparam int      DRAIN_CYCLES   = 24;
    localparam int      PHASE_ITEMS    = 190;
    localparam int      NUM_PHASES     = 8;
    localparam longint  K_HALF_PI      = 64'd1686629713;
    localparam longint  K_ONE          = 64'd1073741824;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    swpd_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    swpd_out_t             out_data;

    // Shadow of the wave registers and the sine table of the model.
    logic [63:0]  wave_regs [0:5];
    longint       sine_tab [0:TBL_SIZE];

    swpd_in_t     pending_points [$];
    swpd_out_t    expected_points [$];

    logic         in_taken;
    logic         out_taken;
    int           in_gap;
    int           out_stall;
    bit           no_idle;
    int           error_count;
    int           points_in;
    int           points_out;
    int           idle_cycles;

    sine_wave_point_displacement_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Quarter-turn cosine in Q30 by a Horner Taylor series.
    function automatic longint cos_q30(longint unsigned r);
        longint unsigned xu;
        longint x;
        longint x2;
        longint acc;
        xu = (r * K_HALF_PI) >> 30;
        x = longint'(xu);
        x2 = (x * x) >>> 30;
        acc = K_ONE;
        for (int k = 6; k >= 1; k--)
        begin
            acc = K_ONE - ((x2 * acc) >>> 30) / longint'((2 * k - 1) * (2 * k));
        end
        return acc;
    endfunction

    function automatic longint sine_entry(longint unsigned i);
        longint unsigned a;
        longint unsigned q;
        longint unsigned r;
        longint c;
        a = (i << (32 - TBL_BITS)) & 64'hFFFF_FFFF;
        q = a >> 30;
        r = a & ((64'd1 << 30) - 1);
        case (q)
            0:       c = cos_q30(r);
            1:       c = -cos_q30((64'd1 << 30) - r);
            2:       c = -cos_q30(r);
            default: c = cos_q30((64'd1 << 30) - r);
        endcase
        return -((c + 64'sd16384) >>> 15);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint lane(int r, int k);
        logic signed [15:0] v;
        v = wave_regs[r][16*k +: 16];
        return longint'(v);
    endfunction

    // Expected displaced point for one input item.
    function automatic swpd_out_t displace_point(swpd_in_t p);
        longint dev_x;
        longint dev_y;
        longint sum_dx;
        longint sum_dy;
        longint proj;
        longint phase;
        longint f;
        longint val;
        longint h;
        longint idx;
        longint t;
        swpd_out_t o;
        t = longint'(p.time_sec);
        dev_x = clamp32(((longint'(p.m_scale_x) * longint'(p.point_x)) >>> FRAC)
                      + ((longint'(p.m_skew_x) * longint'(p.point_y)) >>> FRAC)
                      + longint'(p.m_trans_x));
        dev_y = clamp32(((longint'(p.m_skew_y) * longint'(p.point_x)) >>> FRAC)
                      + ((longint'(p.m_scale_y) * longint'(p.point_y)) >>> FRAC)
                      + longint'(p.m_trans_y));
        sum_dx = 0;
        sum_dy = 0;
        for (int k = 0; k < 4; k++)
        begin
            proj = (lane(2, k) * dev_x + lane(3, k) * dev_y) >>> 15;
            phase = ((lane(1, k) * proj) >>> 12) + ((lane(4, k) * t) >>> 4)
                  + longint'(wave_regs[5][16*k +: 16]) * (64'sd1 << FRAC);
            if (phase < 0)
                phase = -phase;
            idx = (phase >>> FRAC) & (TBL_SIZE - 1);
            f = phase & ((64'sd1 << FRAC) - 1);
            val = sine_tab[idx] * ((64'sd1 << FRAC) - f) + sine_tab[idx + 1] * f;
            h = (lane(0, k) * val) >>> 24;
            sum_dy += (h * lane(3, k)) >>> 15;
            sum_dx += (h * lane(2, k)) >>> 15;
        end
        o.out_x = 32'(clamp32(dev_x + sum_dy));
        o.out_y = 32'(clamp32(dev_y - sum_dx));
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("Mismatch on result %0d, %s: got %h, expected %h",
                 points_out, field, got, want);
    endtask

    // Input driver: holds each item until it is taken, then idles a while.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
                // Hold the item.
            end
            else if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_points.size() != 0)
            begin
                in_data <= pending_points.pop_front();
                in_valid <= 1'b1;
                in_gap <= no_idle ? 0 : $urandom_range(0, 14);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: stalls a random number of cycles after each item.
    always @(negedge clk)
    begin
        int stall;
        if (rst_n)
        begin
            stall = out_stall;
            if (stall != 0)
                stall--;
            else if (out_taken && !no_idle)
                stall = $urandom_range(0, 14);
            out_stall <= stall;
            out_ready <= (stall == 0);
        end
    end

    // Monitor: predicts accepted items and checks the returned points.
    always @(posedge clk)
    begin
        swpd_out_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
            begin
                expected_points.push_back(displace_point(in_data));
                points_in++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    error_count++;
                    $display("Unexpected result %h", out_data);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (out_data.out_x !== want.out_x)
                        report_mismatch("out_x", out_data.out_x, want.out_x);
                    if (out_data.out_y !== want.out_y)
                        report_mismatch("out_y", out_data.out_y, want.out_y);
                end
                points_out++;
            end
        end
    end

    // Watchdog on cycles with no accepted item; covers the table fill too.
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", expected_points.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx <= REG_WAVE_OFFSETS)
            wave_regs[idx] = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] lane_pattern(int kind);
        logic [63:0] v;
        case (kind)
            0:       v = 64'h0;
            1:       v = '1;
            2:       v = 64'h8000_7FFF_8000_7FFF;
            3:       v = 64'h7FFF_8000_7FFF_8000;
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // Moderate wave settings that keep results near the mapped point.
    task automatic write_typical_waves();
        logic [63:0] v [0:5];
        for (int k = 0; k < 4; k++)
        begin
            v[0][16*k +: 16] = 16'($urandom_range(0, 16'h1FFF) - 16'h1000);
            v[1][16*k +: 16] = 16'($urandom_range(0, 16'h3FFF) - 16'h2000);
            v[2][16*k +: 16] = 16'($urandom());
            v[3][16*k +: 16] = 16'($urandom());
            v[4][16*k +: 16] = 16'($urandom_range(0, 16'h7FFF) - 16'h4000);
            v[5][16*k +: 16] = 16'($urandom());
        end
        write_reg(REG_WAVE_AMPLITUDES, v[0]);
        write_reg(REG_WAVE_FREQUENCIES, v[1]);
        write_reg(REG_WAVE_DIRS_X, v[2]);
        write_reg(REG_WAVE_DIRS_Y, v[3]);
        write_reg(REG_WAVE_SPEEDS, v[4]);
        write_reg(REG_WAVE_OFFSETS, v[5]);
    endtask

    function automatic logic [31:0] pick_word(logic [31:0] typical);
        logic [31:0] v;
        case ($urandom_range(0, 11))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h0;
            4:       v = $urandom();
            default: v = typical;
        endcase
        return v;
    endfunction

    // Mostly plausible transforms of pixel-sized points, the rest raw noise.
    function automatic swpd_in_t random_point();
        swpd_in_t p;
        if ($urandom_range(0, 9) < 2)
        begin
            p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
        end
        else
        begin
            p.m_scale_x = pick_word(32'sd65536 + $signed($urandom_range(0, 131071)) - 65536);
            p.m_scale_y = pick_word(32'sd65536 + $signed($urandom_range(0, 131071)) - 65536);
            p.m_skew_x  = pick_word($signed($urandom_range(0, 65535)) - 32768);
            p.m_skew_y  = pick_word($signed($urandom_range(0, 65535)) - 32768);
            p.m_trans_x = pick_word($urandom_range(0, 32'h03FF_FFFF));
            p.m_trans_y = pick_word($urandom_range(0, 32'h03FF_FFFF));
            p.point_x   = pick_word($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
            p.point_y   = pick_word($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
            p.time_sec  = pick_word($urandom_range(0, 32'h00FF_FFFF));
        end
        return p;
    endfunction

    task automatic wait_idle();
        while (pending_points.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        swpd_in_t p;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        in_taken = 1'b0;
        out_taken = 1'b0;
        in_gap = 0;
        out_stall = 0;
        no_idle = 1'b0;
        error_count = 0;
        points_in = 0;
        points_out = 0;
        idle_cycles = 0;
        for (int i = 0; i < 6; i++)
            wave_regs[i] = '0;
        for (int i = 0; i <= TBL_SIZE; i++)
            sine_tab[i] = sine_entry(i);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items at reset settings: plain mapping and overflow.
        p = '0;
        pending_points.push_back(p);
        p = {9{32'h7FFF_FFFF}};
        pending_points.push_back(p);
        p = {9{32'h8000_0000}};
        pending_points.push_back(p);
        p = {9{32'hFFFF_FFFF}};
        pending_points.push_back(p);
        wait_idle();

        // Directed items under typical and extreme waves: phase wrap, output
        // saturation and writes to the two unknown register indexes.
        write_typical_waves();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
        p = '0;
        p.m_scale_x = 32'sd65536;
        p.m_scale_y = 32'sd65536;
        for (int i = 0; i < 6; i++)
        begin
            p.point_x = i * 32'sd1000000;
            p.point_y = -i * 32'sd700000;
            p.time_sec = 32'hFFFF_FFFF >> (i * 5);
            pending_points.push_back(p);
        end
        p.m_trans_x = 32'h7FFF_FF00;
        p.m_trans_y = 32'h8000_0100;
        pending_points.push_back(p);
        wait_idle();
        for (int kind = 1; kind <= 3; kind++)
        begin
            for (int r = 0; r < 6; r++)
                write_reg(CFG_IDX_W'(r), lane_pattern(kind));
            p = '0;
            p.m_trans_x = 32'h7FFF_FFF0;
            p.m_trans_y = 32'h8000_0010;
            p.time_sec = 32'h1234_5678;
            pending_points.push_back(p);
            p = {9{32'h7FFF_FFFF}};
            pending_points.push_back(p);
            p = {9{32'h8000_0000}};
            pending_points.push_back(p);
            wait_idle();
        end

        // Random phases, each under its own settings.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph % 4 == 0)
                write_typical_waves();
            else
                for (int r = 0; r < 6; r++)
                    write_reg(CFG_IDX_W'(r),
                              lane_pattern(ph % 4 == 3 ? 4 : $urandom_range(0, 4)));
            no_idle = (ph % 3 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_points.push_back(random_point());
            wait_idle();
        end

        $display("Checked %0d results from %0d items over %0d random phases.",
                 points_out, points_in, NUM_PHASES);
        $display("Settings included all-zero, all-one, extreme and random lanes.");
        if (error_count == 0 && expected_points.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
